@@ design/nibble_mailbox_sound_comm_macros.svh @@
// ----------------------------------------------------------------------------
// Nibble mailbox assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_MAILBOX_SOUND_COMM_MACROS_SVH
`define NIBBLE_MAILBOX_SOUND_COMM_MACROS_SVH

// Same-cycle implication.
`define NMSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NMSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/nmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Nibble mailbox package
// Access codes, error codes and the result record shared by the mailbox files.
// ----------------------------------------------------------------------------
package nmsc_pkg;

    typedef enum logic [2:0] {
        FUNC_MAIN_MODE  = 3'd0,
        FUNC_MAIN_WR    = 3'd1,
        FUNC_MAIN_RD    = 3'd2,
        FUNC_SLAVE_MODE = 3'd3,
        FUNC_SLAVE_WR   = 3'd4,
        FUNC_SLAVE_RD   = 3'd5,
        FUNC_IRQ_LINE   = 3'd6,
        FUNC_POLL       = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_UNEXP    = 2'd1,
        ERR_MODE_MID = 2'd2,
        ERR_INT_MODE = 2'd3
    } t_err;

    // NMI enable field of a slave mode write
    localparam logic [1:0] NMI_MODE_KEEP    = 2'd0;
    localparam logic [1:0] NMI_MODE_DISABLE = 2'd1;
    localparam logic [1:0] NMI_MODE_ENABLE  = 2'd2;

    // Nibbles left in a transfer
    localparam logic [1:0] CNT_IDLE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // Status bit positions
    localparam int unsigned ST_CMD_PEND   = 0;
    localparam int unsigned ST_REPLY_PEND = 2;

    localparam int unsigned RESULT_W = 13;
    localparam int unsigned M_TDATA_W = 16;

    // Packed lowest field last: read_data in bits 7:0
    typedef struct packed {
        t_err       error_code;
        logic       sound_reset;
        logic       nmi_fire;
        logic       irq_fire;
        logic [7:0] read_data;
    } t_result;

endpackage

@@ design/nmsc_core.sv @@
// ----------------------------------------------------------------------------
// Nibble mailbox core
// Holds the mailbox state and forms the result of one bus access.
// ----------------------------------------------------------------------------
module nmsc_core
    import nmsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_func      i_func,
    input  logic [7:0] i_data,
    output t_result    o_result
);

    logic [1:0] r_main_count,  n_main_count;
    logic       r_main_two,    n_main_two;
    logic [3:0] r_main_low,    n_main_low;
    logic [1:0] r_slave_count, n_slave_count;
    logic       r_slave_two,   n_slave_two;
    logic [3:0] r_slave_low,   n_slave_low;
    logic [2:0] r_status,      n_status;
    logic [7:0] r_cmd,         n_cmd;
    logic [7:0] r_reply,       n_reply;
    logic       r_nmi_en,      n_nmi_en;
    logic       r_nmi_pend,    n_nmi_pend;
    logic       r_irq_pend,    n_irq_pend;
    logic [7:0] r_slave_last,  n_slave_last;
    logic       r_reset_lvl,   n_reset_lvl;

    logic [3:0] w_nib;
    logic [1:0] w_main_dec;
    logic [1:0] w_slave_dec;
    logic       w_run_ctl;

    assign w_nib       = i_data[3:0];
    assign w_main_dec  = r_main_count - 2'd1;
    assign w_slave_dec = r_slave_count - 2'd1;

    always_comb begin
        n_main_count  = r_main_count;
        n_main_two    = r_main_two;
        n_main_low    = r_main_low;
        n_slave_count = r_slave_count;
        n_slave_two   = r_slave_two;
        n_slave_low   = r_slave_low;
        n_status      = r_status;
        n_cmd         = r_cmd;
        n_reply       = r_reply;
        n_nmi_en      = r_nmi_en;
        n_nmi_pend    = r_nmi_pend;
        n_irq_pend    = r_irq_pend;
        n_slave_last  = r_slave_last;
        n_reset_lvl   = r_reset_lvl;
        o_result      = '0;
        o_result.error_code = ERR_OK;
        w_run_ctl     = 1'b0;

        unique case (i_func)
            FUNC_MAIN_MODE: begin
                n_main_two   = ~i_data[2];
                n_main_count = i_data[2] ? CNT_ONE : CNT_TWO;
                n_main_low   = '0;
            end
            FUNC_MAIN_WR: begin
                if (r_main_count == CNT_IDLE) begin
                    o_result.error_code = ERR_UNEXP;
                end else begin
                    if (r_main_count == CNT_TWO) begin
                        n_main_low = w_nib;
                    end
                    n_main_count = w_main_dec;
                    if (w_main_dec == CNT_IDLE) begin
                        if (r_main_two) begin
                            n_cmd      = {w_nib, r_main_low};
                            n_status[ST_CMD_PEND] = 1'b1;
                            n_nmi_pend = 1'b1;
                        end else begin
                            n_reset_lvl  = |w_nib;
                            n_main_count = CNT_ONE;
                        end
                    end
                end
            end
            FUNC_MAIN_RD: begin
                if (r_main_two) begin
                    // Count stops at zero
                    if (r_main_count != CNT_IDLE) begin
                        n_main_count = w_main_dec;
                    end
                    n_status[ST_REPLY_PEND] = 1'b0;
                    if (n_main_count == CNT_ONE) begin
                        o_result.read_data = {4'd0, r_reply[3:0]};
                    end else begin
                        o_result.read_data = {4'd0, r_reply[7:4]};
                    end
                end else begin
                    o_result.read_data = {5'd0, r_status};
                end
            end
            FUNC_SLAVE_MODE: begin
                if (r_slave_count != CNT_IDLE) begin
                    o_result.error_code = ERR_MODE_MID;
                end
                n_slave_two   = ~i_data[2];
                n_slave_count = i_data[2] ? CNT_ONE : CNT_TWO;
                n_slave_low   = '0;
                case (i_data[1:0])
                    NMI_MODE_KEEP:    ;
                    NMI_MODE_DISABLE: n_nmi_en = 1'b0;
                    NMI_MODE_ENABLE:  n_nmi_en = 1'b1;
                    default: begin
                        if (r_slave_count == CNT_IDLE) begin
                            o_result.error_code = ERR_INT_MODE;
                        end
                    end
                endcase
            end
            FUNC_SLAVE_WR: begin
                w_run_ctl = 1'b1;
                if (r_slave_count == CNT_IDLE) begin
                    o_result.error_code = ERR_UNEXP;
                end else begin
                    if (r_slave_count == CNT_TWO) begin
                        n_slave_low = w_nib;
                    end
                    n_slave_count = w_slave_dec;
                    if (w_slave_dec == CNT_IDLE && r_slave_two) begin
                        n_reply = {w_nib, r_slave_low};
                        n_status[ST_REPLY_PEND] = 1'b1;
                    end
                end
            end
            FUNC_SLAVE_RD: begin
                w_run_ctl = 1'b1;
                if (r_slave_count == CNT_IDLE) begin
                    o_result.error_code = ERR_UNEXP;
                end else begin
                    if (!r_slave_two) begin
                        n_slave_last = {5'd0, r_status};
                    end else if (r_slave_count == CNT_TWO) begin
                        n_slave_last = {4'd0, r_cmd[3:0]};
                    end else begin
                        n_slave_last = {4'd0, r_cmd[7:4]};
                        n_status[ST_CMD_PEND] = 1'b0;
                    end
                    n_slave_count = w_slave_dec;
                end
                o_result.read_data = n_slave_last;
            end
            FUNC_IRQ_LINE: begin
                n_irq_pend = i_data[0];
            end
            FUNC_POLL: begin
                w_run_ctl = 1'b1;
            end
        endcase

        // Interrupt controller: IRQ is level driven, NMI is consumed
        if (w_run_ctl) begin
            o_result.irq_fire = r_irq_pend;
            if (r_nmi_pend && r_nmi_en) begin
                o_result.nmi_fire = 1'b1;
                n_nmi_pend        = 1'b0;
            end
        end
        o_result.sound_reset = n_reset_lvl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_count  <= CNT_IDLE;
            r_main_two    <= 1'b0;
            r_main_low    <= '0;
            r_slave_count <= CNT_IDLE;
            r_slave_two   <= 1'b0;
            r_slave_low   <= '0;
            r_status      <= '0;
            r_cmd         <= '0;
            r_reply       <= '0;
            r_nmi_en      <= 1'b0;
            r_nmi_pend    <= 1'b0;
            r_irq_pend    <= 1'b0;
            r_slave_last  <= '0;
            r_reset_lvl   <= 1'b0;
        end else if (i_accept) begin
            r_main_count  <= n_main_count;
            r_main_two    <= n_main_two;
            r_main_low    <= n_main_low;
            r_slave_count <= n_slave_count;
            r_slave_two   <= n_slave_two;
            r_slave_low   <= n_slave_low;
            r_status      <= n_status;
            r_cmd         <= n_cmd;
            r_reply       <= n_reply;
            r_nmi_en      <= n_nmi_en;
            r_nmi_pend    <= n_nmi_pend;
            r_irq_pend    <= n_irq_pend;
            r_slave_last  <= n_slave_last;
            r_reset_lvl   <= n_reset_lvl;
        end
    end

endmodule

@@ design/nibble_mailbox_sound_comm.sv @@
// ----------------------------------------------------------------------------
// Nibble mailbox between main CPU and sound CPU
// Top level: access stream in, one result transaction out per access.
// ----------------------------------------------------------------------------
// Every bus access or interrupt event enters as one slave-side transaction
// (kind in s_axis_tuser, write byte in s_axis_tdata) and yields exactly one
// master-side transaction, held in the output register or skid entry. Mailbox state
// updates in the cycle the access is taken, so one access per clock is sustained;
// the only thing that throttles the input is a full two-entry output buffer
// (output register plus skid entry) while downstream holds m_axis_tready low.
// read_data is zero for every access except comm reads; sound_reset always
// shows the reset line level after the access.
module nibble_mailbox_sound_comm
    import nmsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data
    input  logic [2:0]  s_axis_tuser,   // [2:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] read_data, [8] irq_fire,
                                        // [9] nmi_fire, [10] sound_reset,
                                        // [12:11] error_code, [15:13] zero
);

`include "nibble_mailbox_sound_comm_macros.svh"

    logic    w_accept;
    logic    w_take;
    t_func   w_func;
    t_result w_result;

    logic    r_out_valid,  n_out_valid;
    t_result r_out_data,   n_out_data;
    logic    r_skid_valid, n_skid_valid;
    t_result r_skid_data,  n_skid_data;

    assign w_func        = t_func'(s_axis_tuser);
    assign s_axis_tready = ~r_skid_valid;
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_take        = r_out_valid & m_axis_tready;

    nmsc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_func   (w_func),
        .i_data   (s_axis_tdata),
        .o_result (w_result)
    );

    // Output register with skid entry: refill from skid first, then from input
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_accept;
                n_out_data  = w_result;
            end
        end else if (w_accept) begin
            // Output stalled: hold the new result in the skid entry
            n_skid_valid = 1'b1;
            n_skid_data  = w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - RESULT_W)'(0), r_out_data};

    `NMSC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid entry filled while output register empty")
    `NMSC_ASSERT_NOW(a_main_rd_no_err, w_accept && w_func == FUNC_MAIN_RD, w_result.error_code == ERR_OK, "main read reported an error")
    `NMSC_ASSERT_NOW(a_irq_only_ctl, w_accept && w_result.irq_fire, w_func == FUNC_SLAVE_WR || w_func == FUNC_SLAVE_RD || w_func == FUNC_POLL, "IRQ fired outside a controller run")
    `NMSC_ASSERT_NEXT(a_accept_shows, w_accept, r_out_valid, "accepted access left no result")

endmodule
